>>> rtl/bnrf_pkg.sv
// Shared types and constants for the binary neighbor-rule pixel filter.
// No dependencies; imported by the front end, back end and top level.
package bnrf_pkg;

	// Fixed field and register widths
	localparam int ROW_W      = 12;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 12;
	localparam int VAL_W      = 8;

	// Frame limits and reset values
	localparam int MIN_DIM      = 3;
	localparam int WIDTH_RESET  = 640;
	localparam int HEIGHT_RESET = 480;
	localparam int SPARSE_RESET = 128;
	localparam int DENSE_RESET  = 255;

	// Fewer occupied ring neighbors than this gives the sparse value
	localparam logic [3:0] RING_LIMIT = 4'd4;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIDTH  = 4'd0,
		REG_HEIGHT = 4'd1,
		REG_SPARSE = 4'd2,
		REG_DENSE  = 4'd3
	} cfg_reg_t;

	// Results carried by one pixel word, in emission order (bit 0 first)
	typedef struct packed {
		logic echo;   // top/bottom row pixel echoed on arrival
		logic redge;  // right-edge pixel of the row above
		logic centre; // filtered pixel at row-1, col-1
	} res_mask_t;

	localparam int RES_CENTRE = 0;
	localparam int RES_REDGE  = 1;
	localparam int RES_ECHO   = 2;
	localparam int RES_N      = 3;

endpackage

>>> rtl/binary_neighbor_rule_pixel_filter_core.sv
// Top level of the binary neighbor-rule pixel filter: config registers,
// front end, word queue and back end. Depends on bnrf_pkg and all rtl modules.
//
// Pixels enter in raster order through push/full and leave, tagged with row
// and column, through empty/pop. The input side takes one pixel per clock
// while full is low; the front end reads both line stores (registered-read
// RAMs, one read port each) on accept and applies the neighbor rule in the
// next cycle, then parks a word of up to three results in a four-entry queue.
// The back end drains it one result per clock while pop takes them; a pixel's
// first result passes the stage registers, a queue slot and the output
// register before it is shown. Interior pixels give one result each; the last
// pixel of an interior row, and bottom row pixels that also close the row
// above, give two or three, and the queue absorbs those bursts. full rises
// when the queue plus the word in flight would fill it. Line stores need no
// clearing pass: their entries are always written before an interior row
// reads them. The user must write registers through cfg_valid/cfg_ready
// (always ready) only while the block is idle; the block does not enforce
// it. Width and height are clamped into range as they are written.
module binary_neighbor_rule_pixel_filter_core import bnrf_pkg::*; #(
	parameter int MAX_WIDTH = 2048,
	parameter int PIXEL_BITS = 8,
	localparam int CW = $clog2(MAX_WIDTH)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// pixel input
	input  logic                  push,
	output logic                  full,
	input  logic [PIXEL_BITS-1:0] pixel_in,
	// results
	output logic                  empty,
	input  logic                  pop,
	output logic [PIXEL_BITS-1:0] pixel_out,
	output logic [ROW_W-1:0]      out_row,
	output logic [CW-1:0]         out_col,
	output logic                  last_of_run,
	// register writes
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int QDEPTH = 4;
	localparam int QCNT_W = $clog2(QDEPTH + 1);
	localparam int QW     = RES_N + ROW_W + CW + 3 * PIXEL_BITS;
	localparam int WB     = (CW + 2 > CFG_DATA_W) ? CW + 2 : CFG_DATA_W;
	localparam int W_RST  = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;

	// Config: store last column / last row, already clamped
	logic [CW-1:0]         col_last_q;
	logic [ROW_W-1:0]      row_last_q;
	logic [PIXEL_BITS-1:0] sparse_q;
	logic [PIXEL_BITS-1:0] dense_q;
	logic                  cfg_we;
	logic [WB-1:0]         w_req;
	logic [CW-1:0]         col_last_new;
	logic [ROW_W-1:0]      h_req;
	logic [ROW_W-1:0]      row_last_new;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	// width clamped to MIN_DIM..MAX_WIDTH, height to MIN_DIM..4095
	assign w_req = WB'(cfg_data);
	assign h_req = ROW_W'(cfg_data);

	always_comb begin
		if (w_req < WB'(MIN_DIM)) begin
			col_last_new = CW'(MIN_DIM - 1);
		end else if (w_req > WB'(MAX_WIDTH)) begin
			col_last_new = CW'(MAX_WIDTH - 1);
		end else begin
			col_last_new = CW'(w_req - WB'(1));
		end
		if (h_req < ROW_W'(MIN_DIM)) begin
			row_last_new = ROW_W'(MIN_DIM - 1);
		end else begin
			row_last_new = h_req - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_last_q <= CW'(W_RST - 1);
			row_last_q <= ROW_W'(HEIGHT_RESET - 1);
			sparse_q   <= PIXEL_BITS'(SPARSE_RESET);
			dense_q    <= PIXEL_BITS'(DENSE_RESET);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WIDTH:  col_last_q <= col_last_new;
				REG_HEIGHT: row_last_q <= row_last_new;
				REG_SPARSE: sparse_q   <= PIXEL_BITS'(cfg_data[VAL_W-1:0]);
				REG_DENSE:  dense_q    <= PIXEL_BITS'(cfg_data[VAL_W-1:0]);
				default: ;
			endcase
		end
	end

	// Flow control: a pixel is taken only if its word is sure of a queue slot
	logic              in_acc;
	logic              busy_s1;
	logic [QCNT_W-1:0] q_count;
	logic [QCNT_W:0]   q_inflight;

	assign q_inflight = (QCNT_W + 1)'(q_count) + (QCNT_W + 1)'(busy_s1);
	assign full       = (q_inflight >= (QCNT_W + 1)'(QDEPTH));
	assign in_acc     = push && !full;

	// Front end
	logic                  f_push;
	res_mask_t             f_mask;
	logic [ROW_W-1:0]      f_row;
	logic [CW-1:0]         f_col;
	logic [PIXEL_BITS-1:0] f_centre;
	logic [PIXEL_BITS-1:0] f_redge;
	logic [PIXEL_BITS-1:0] f_echo;

	bnrf_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.PIXEL_BITS(PIXEL_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_acc      (in_acc),
		.pixel_in    (pixel_in),
		.col_last    (col_last_q),
		.row_last    (row_last_q),
		.sparse_value(sparse_q),
		.dense_value (dense_q),
		.busy_s1     (busy_s1),
		.q_push      (f_push),
		.q_mask      (f_mask),
		.q_row       (f_row),
		.q_col       (f_col),
		.q_centre    (f_centre),
		.q_redge     (f_redge),
		.q_echo      (f_echo)
	);

	// Word queue
	logic [QW-1:0]         q_wdata;
	logic [QW-1:0]         q_rdata;
	logic                  q_nonempty;
	logic                  q_pop;
	res_mask_t             h_mask;
	logic [ROW_W-1:0]      h_row;
	logic [CW-1:0]         h_col;
	logic [PIXEL_BITS-1:0] h_centre;
	logic [PIXEL_BITS-1:0] h_redge;
	logic [PIXEL_BITS-1:0] h_echo;

	assign q_wdata = {f_mask, f_row, f_col, f_centre, f_redge, f_echo};
	assign {h_mask, h_row, h_col, h_centre, h_redge, h_echo} = q_rdata;

	bnrf_queue #(
		.WIDTH(QW),
		.DEPTH(QDEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (f_push),
		.wdata   (q_wdata),
		.pop     (q_pop),
		.rdata   (q_rdata),
		.count   (q_count),
		.nonempty(q_nonempty)
	);

	// Back end
	logic out_valid;

	bnrf_back #(
		.MAX_WIDTH (MAX_WIDTH),
		.PIXEL_BITS(PIXEL_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_nonempty),
		.head_mask  (h_mask),
		.head_row   (h_row),
		.head_col   (h_col),
		.head_centre(h_centre),
		.head_redge (h_redge),
		.head_echo  (h_echo),
		.head_pop   (q_pop),
		.out_take   (pop && out_valid),
		.out_valid  (out_valid),
		.out_pixel  (pixel_out),
		.out_row    (out_row),
		.out_col    (out_col),
		.out_last   (last_of_run)
	);

	assign empty = !out_valid;

endmodule

>>> rtl/bnrf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the two line stores.
module bnrf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/bnrf_queue.sv
// Small flop-based FIFO between the front end and the back end.
// No dependencies.
module bnrf_queue #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4,
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic [CNT_W-1:0] count,
	output logic             nonempty
);

	logic [WIDTH-1:0] slots_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

	assign rdata    = slots_q[rd_ptr_q];
	assign count    = count_q;
	assign nonempty = (count_q != '0);

endmodule

>>> rtl/bnrf_front.sv
// Front end: raster counters, line stores, 3x3 window and the neighbor rule.
// Uses bnrf_pkg and bnrf_ram. Emits a classified word per pixel with results.
module bnrf_front import bnrf_pkg::*; #(
	parameter int MAX_WIDTH = 2048,
	parameter int PIXEL_BITS = 8,
	localparam int CW = $clog2(MAX_WIDTH)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_acc,
	input  logic [PIXEL_BITS-1:0] pixel_in,
	input  logic [CW-1:0]         col_last,
	input  logic [ROW_W-1:0]      row_last,
	input  logic [PIXEL_BITS-1:0] sparse_value,
	input  logic [PIXEL_BITS-1:0] dense_value,
	output logic                  busy_s1,
	output logic                  q_push,
	output res_mask_t             q_mask,
	output logic [ROW_W-1:0]      q_row,
	output logic [CW-1:0]         q_col,
	output logic [PIXEL_BITS-1:0] q_centre,
	output logic [PIXEL_BITS-1:0] q_redge,
	output logic [PIXEL_BITS-1:0] q_echo
);

	logic [CW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;
	logic [CW-1:0]    col_eff;
	logic [ROW_W-1:0] row_eff;
	logic             col_end;
	logic             row_end;

	logic                  valid_s1;
	logic [PIXEL_BITS-1:0] pix_s1;
	logic [ROW_W-1:0]      row_s1;
	logic [CW-1:0]         col_s1;
	res_mask_t             mask_s1;
	logic                  lcol_s1;

	logic [PIXEL_BITS-1:0] up_v;
	logic [PIXEL_BITS-1:0] mid_v;

	// Window columns 1 and 2 (column 0 is only ever the shifted-out column 1)
	logic [PIXEL_BITS-1:0] win_q [3][2];
	logic [PIXEL_BITS-1:0] nw [3][3];
	logic [3:0]            ring_cnt;
	logic [PIXEL_BITS-1:0] centre_v;
	logic [PIXEL_BITS-1:0] filt_v;

	// Counters may sit past a shrunk frame after a config write: clamp them
	assign col_eff = (col_q > col_last) ? col_last : col_q;
	assign row_eff = (row_q > row_last) ? row_last : row_q;
	assign col_end = (col_eff == col_last);
	assign row_end = (row_eff == row_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_acc;
			if (in_acc) begin
				if (col_end) begin
					col_q <= '0;
					row_q <= row_end ? '0 : row_eff + 1'b1;
				end else begin
					col_q <= col_eff + 1'b1;
					row_q <= row_eff;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pix_s1         <= pixel_in;
			row_s1         <= row_eff;
			col_s1         <= col_eff;
			mask_s1.centre <= (row_eff >= ROW_W'(2)) && (col_eff != '0);
			mask_s1.redge  <= (row_eff >= ROW_W'(2)) && col_end;
			mask_s1.echo   <= (row_eff == '0) || row_end;
			lcol_s1        <= (col_eff == CW'(1));
		end
	end

	// Line stores: read on accept, write back in the next cycle, same column
	bnrf_ram #(
		.WIDTH(PIXEL_BITS),
		.DEPTH(MAX_WIDTH)
	) u_upper (
		.clk  (clk),
		.we   (valid_s1),
		.waddr(col_s1),
		.wdata(mid_v),
		.re   (in_acc),
		.raddr(col_eff),
		.rdata(up_v)
	);

	bnrf_ram #(
		.WIDTH(PIXEL_BITS),
		.DEPTH(MAX_WIDTH)
	) u_middle (
		.clk  (clk),
		.we   (valid_s1),
		.waddr(col_s1),
		.wdata(pix_s1),
		.re   (in_acc),
		.raddr(col_eff),
		.rdata(mid_v)
	);

	// Shifted window
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			nw[i][0] = win_q[i][0];
			nw[i][1] = win_q[i][1];
		end
		nw[0][2] = up_v;
		nw[1][2] = mid_v;
		nw[2][2] = pix_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				win_q[i][0] <= '0;
				win_q[i][1] <= '0;
			end
		end else if (valid_s1) begin
			for (int i = 0; i < 3; i++) begin
				win_q[i][0] <= nw[i][1];
				win_q[i][1] <= nw[i][2];
			end
		end
	end

	// Neighbor rule on the window centre
	always_comb begin
		ring_cnt = '0;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				if (!(i == 1 && j == 1)) begin
					ring_cnt = ring_cnt + 4'(nw[i][j] != '0);
				end
			end
		end
	end

	assign centre_v = nw[1][1];

	always_comb begin
		if (lcol_s1 || (centre_v == '0)) begin
			filt_v = centre_v;
		end else if (((nw[1][0] != '0) && (nw[1][2] != '0)) ||
			((nw[0][1] != '0) && (nw[2][1] != '0))) begin
			filt_v = centre_v;
		end else if (ring_cnt < RING_LIMIT) begin
			filt_v = sparse_value;
		end else begin
			filt_v = dense_value;
		end
	end

	assign busy_s1  = valid_s1;
	assign q_push   = valid_s1 && (mask_s1 != '0);
	assign q_mask   = mask_s1;
	assign q_row    = row_s1;
	assign q_col    = col_s1;
	assign q_centre = filt_v;
	assign q_redge  = mid_v;
	assign q_echo   = pix_s1;

endmodule

>>> rtl/bnrf_back.sv
// Back end: unpacks a classified word into up to three results, one per cycle
// while the receiver pops them, into the output register. Depends on bnrf_pkg.
module bnrf_back import bnrf_pkg::*; #(
	parameter int MAX_WIDTH = 2048,
	parameter int PIXEL_BITS = 8,
	localparam int CW = $clog2(MAX_WIDTH)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  head_valid,
	input  res_mask_t             head_mask,
	input  logic [ROW_W-1:0]      head_row,
	input  logic [CW-1:0]         head_col,
	input  logic [PIXEL_BITS-1:0] head_centre,
	input  logic [PIXEL_BITS-1:0] head_redge,
	input  logic [PIXEL_BITS-1:0] head_echo,
	output logic                  head_pop,
	input  logic                  out_take,
	output logic                  out_valid,
	output logic [PIXEL_BITS-1:0] out_pixel,
	output logic [ROW_W-1:0]      out_row,
	output logic [CW-1:0]         out_col,
	output logic                  out_last
);

	logic [RES_N-1:0] done_q;
	logic [RES_N-1:0] rem;
	logic [RES_N-1:0] pick;
	logic             pick_last;
	logic             can_load;
	logic             load;

	logic                  out_valid_q;
	logic [PIXEL_BITS-1:0] pixel_q;
	logic [ROW_W-1:0]      row_q;
	logic [CW-1:0]         col_q;
	logic                  last_q;

	logic [PIXEL_BITS-1:0] sel_pixel;
	logic [ROW_W-1:0]      sel_row;
	logic [CW-1:0]         sel_col;

	assign rem = head_mask & ~done_q;

	always_comb begin
		pick = '0;
		if (rem[RES_CENTRE]) begin
			pick[RES_CENTRE] = 1'b1;
		end else if (rem[RES_REDGE]) begin
			pick[RES_REDGE] = 1'b1;
		end else begin
			pick[RES_ECHO] = 1'b1;
		end
	end

	assign pick_last = ((rem & ~pick) == '0);
	assign can_load  = !out_valid_q || out_take;
	assign load      = can_load && head_valid;
	assign head_pop  = load && pick_last;

	always_comb begin
		if (pick[RES_CENTRE]) begin
			sel_pixel = head_centre;
			sel_row   = head_row - 1'b1;
			sel_col   = head_col - 1'b1;
		end else if (pick[RES_REDGE]) begin
			sel_pixel = head_redge;
			sel_row   = head_row - 1'b1;
			sel_col   = head_col;
		end else begin
			sel_pixel = head_echo;
			sel_row   = head_row;
			sel_col   = head_col;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				done_q <= pick_last ? '0 : (done_q | pick);
			end
			if (can_load) begin
				out_valid_q <= head_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pixel_q <= sel_pixel;
			row_q   <= sel_row;
			col_q   <= sel_col;
			last_q  <= pick_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_pixel = pixel_q;
	assign out_row   = row_q;
	assign out_col   = col_q;
	assign out_last  = last_q;

endmodule

>>> tb/binary_neighbor_rule_pixel_filter_core_tb.sv
// Self-checking testbench for binary_neighbor_rule_pixel_filter_core.
// Streams raster pixels through push/full, predicts every tagged result and
// checks the empty/pop side field by field. Depends on bnrf_pkg and the RTL.
module binary_neighbor_rule_pixel_filter_core_tb;
	import bnrf_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_W = 2048;
	localparam int MAX_H = 4095;
	localparam int PIX_W = 8;
	localparam int COL_W = $clog2(MAX_W);

	localparam int DIRECTED_ITEMS = 29;
	localparam int RANDOM_ITEMS   = 320;
	localparam int DRAIN_CYCLES   = 12;
	localparam int HOLD_CYCLES    = 150;  // long receiver stall to back the block up
	localparam int REPORT_CAP     = 100;

	// one expected output word
	typedef struct packed {
		logic [PIX_W-1:0] pix;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             last;
	} px_tag_t;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  push = 1'b0;
	logic                  full;
	logic [PIX_W-1:0]      pixel_in = '0;
	logic                  empty;
	logic                  pop = 1'b0;
	logic [PIX_W-1:0]      pixel_out;
	logic [ROW_W-1:0]      out_row;
	logic [COL_W-1:0]      out_col;
	logic                  last_of_run;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	cfg_reg_t              cfg_index = REG_WIDTH;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	binary_neighbor_rule_pixel_filter_core uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.pixel_in    (pixel_in),
		.empty       (empty),
		.pop         (pop),
		.pixel_out   (pixel_out),
		.out_row     (out_row),
		.out_col     (out_col),
		.last_of_run (last_of_run),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	// ------------------------------------------------------------------
	// Filter state mirror: line stores, 3x3 window, raster position and
	// the register copies. Width/height are kept raw and clamped on use.
	// ------------------------------------------------------------------
	logic [PIX_W-1:0]      ls_upper  [MAX_W];
	logic [PIX_W-1:0]      ls_middle [MAX_W];
	logic [PIX_W-1:0]      win [3][3];
	int unsigned           next_row;
	int unsigned           next_col;
	logic [CFG_DATA_W-1:0] width_reg;
	logic [CFG_DATA_W-1:0] height_reg;
	logic [VAL_W-1:0]      sparse_val;
	logic [VAL_W-1:0]      dense_val;

	logic [PIX_W-1:0] pixel_backlog [$];  // words waiting for the driver
	px_tag_t          expected_px   [$];  // tagged results not yet popped
	px_tag_t          want_px;

	int unsigned send_idle_pct = 9;
	int unsigned recv_idle_pct = 45;
	bit          hold_armed = 1'b0;
	logic        rx_hold = 1'b0;

	int unsigned items_queued    = 0;
	int unsigned pixels_accepted = 0;
	int unsigned results_checked = 0;
	int unsigned mismatches      = 0;

	// Directed content. First 20: a 5x4 frame whose interior hits a zero
	// centre, a left/right pair, an up/down pair, three occupied neighbors
	// (sparse) and five (dense). Last 9: a 3x3 frame with exactly four
	// occupied neighbors around the centre.
	logic [PIX_W-1:0] directed_px [DIRECTED_ITEMS] = '{
		8'd255, 8'd170, 8'd0,  8'd85, 8'd1,
		8'd128, 8'd11,  8'd64, 8'd0,  8'd2,
		8'd0,   8'd33,  8'd0,  8'd99, 8'd0,
		8'd7,   8'd200, 8'd5,  8'd0,  8'd0,
		8'd1,   8'd0,   8'd128,
		8'd0,   8'd77,  8'd2,
		8'd0,   8'd0,   8'd64
	};

	function automatic int unsigned eff_width();
		if (width_reg < MIN_DIM) return MIN_DIM;
		if (width_reg > MAX_W) return MAX_W;
		return width_reg;
	endfunction

	function automatic int unsigned eff_height();
		if (height_reg < MIN_DIM) return MIN_DIM;
		if (height_reg > MAX_H) return MAX_H;
		return height_reg;
	endfunction

	function automatic px_tag_t tag_result(input logic [PIX_W-1:0] pix,
			input int unsigned row, input int unsigned col);
		px_tag_t t;
		t.pix  = pix;
		t.row  = ROW_W'(row);
		t.col  = COL_W'(col);
		t.last = 1'b0;
		return t;
	endfunction

	// Neighbor rule applied to the window centre
	function automatic logic [PIX_W-1:0] filtered_centre(input logic on_edge);
		logic [PIX_W-1:0] centre;
		logic             lr_pair;
		logic             ud_pair;
		int unsigned      ring;
		int               i;
		int               j;
		centre = win[1][1];
		if (on_edge || centre == '0) return centre;
		lr_pair = (win[1][0] != '0) && (win[1][2] != '0);
		ud_pair = (win[0][1] != '0) && (win[2][1] != '0);
		if (lr_pair || ud_pair) return centre;
		ring = 0;
		for (i = 0; i < 3; i++)
			for (j = 0; j < 3; j++)
				if (!(i == 1 && j == 1) && win[i][j] != '0) ring++;
		return (ring < RING_LIMIT) ? sparse_val : dense_val;
	endfunction

	// Advance the mirror by one accepted pixel and queue what it emits
	function automatic void predict_pixel(input logic [PIX_W-1:0] pix);
		int unsigned w;
		int unsigned h;
		int unsigned r;
		int unsigned c;
		int          n;
		int          i;
		px_tag_t     res [3];
		w = eff_width();
		h = eff_height();
		r = next_row;
		c = next_col;
		n = 0;
		// a shrinking register write can leave the counters past the end
		if (c > w - 1) c = w - 1;
		if (r > h - 1) r = h - 1;
		for (i = 0; i < 3; i++) begin
			win[i][0] = win[i][1];
			win[i][1] = win[i][2];
		end
		win[0][2] = ls_upper[c];
		win[1][2] = ls_middle[c];
		win[2][2] = pix;
		ls_upper[c]  = ls_middle[c];
		ls_middle[c] = pix;
		// interior row above: centre lags one column, row end flushes the edge
		if (r >= 2 && c >= 1) begin
			res[n] = tag_result(filtered_centre(c == 1), r - 1, c - 1);
			n++;
			if (c == w - 1) begin
				res[n] = tag_result(win[1][2], r - 1, c);
				n++;
			end
		end
		// top and bottom rows echo on arrival
		if (r == 0 || r == h - 1) begin
			res[n] = tag_result(pix, r, c);
			n++;
		end
		if (n > 0) res[n-1].last = 1'b1;
		for (i = 0; i < n; i++) expected_px.push_back(res[i]);
		if (c >= w - 1) begin
			next_col = 0;
			next_row = (r >= h - 1) ? 0 : r + 1;
		end else begin
			next_col = c + 1;
			next_row = r;
		end
	endfunction

	// ------------------------------------------------------------------
	// Clock, pressure and limit
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// one long receiver stall while the sender keeps offering pixels
	initial begin
		wait (hold_armed);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	end

	initial begin
		#(64'd40_000_000);
		$display("Timeout: %0d results still outstanding", expected_px.size());
		$display("FAILED: results differ");
		$finish;
	end

	// ------------------------------------------------------------------
	// Driver: one pixel word per accepted push, held while full is high
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push     <= 1'b0;
			pixel_in <= '0;
		end else begin
			if (push && !full) begin
				predict_pixel(pixel_in);
				pixels_accepted++;
			end
			if (!push || !full) begin
				if (pixel_backlog.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
					push     <= 1'b1;
					pixel_in <= pixel_backlog.pop_front();
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: every popped word is checked against the oldest expectation
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				results_checked++;
				if (expected_px.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_CAP)
						$error("unexpected word: row %0d col %0d pixel %0d",
							out_row, out_col, pixel_out);
				end else begin
					want_px = expected_px.pop_front();
					if (pixel_out !== want_px.pix) begin
						mismatches++;
						if (mismatches <= REPORT_CAP)
							$error("pixel_out: expected %0d, got %0d (row %0d col %0d)",
								want_px.pix, pixel_out, want_px.row, want_px.col);
					end
					if (out_row !== want_px.row) begin
						mismatches++;
						if (mismatches <= REPORT_CAP)
							$error("out_row: expected %0d, got %0d", want_px.row, out_row);
					end
					if (out_col !== want_px.col) begin
						mismatches++;
						if (mismatches <= REPORT_CAP)
							$error("out_col: expected %0d, got %0d", want_px.col, out_col);
					end
					if (last_of_run !== want_px.last) begin
						mismatches++;
						if (mismatches <= REPORT_CAP)
							$error("last_of_run: expected %0d, got %0d (row %0d col %0d)",
								want_px.last, last_of_run, want_px.row, want_px.col);
					end
				end
			end
			pop <= !rx_hold && ($urandom_range(99, 0) >= recv_idle_pct);
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	task automatic write_reg(input cfg_reg_t idx, input int unsigned data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_DATA_W'(data);
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_WIDTH:  width_reg  = CFG_DATA_W'(data);
			REG_HEIGHT: height_reg = CFG_DATA_W'(data);
			REG_SPARSE: sparse_val = VAL_W'(data);
			REG_DENSE:  dense_val  = VAL_W'(data);
			default: ;
		endcase
		cfg_valid <= 1'b0;
	endtask

	// block must be quiet before registers change: backlog sent, all
	// results popped, plus a few clocks for pixels that emit nothing
	task automatic drain();
		while (pixel_backlog.size() != 0 || push || expected_px.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [PIX_W-1:0] random_pixel(input int unsigned occ_pct);
		int unsigned pick;
		pick = $urandom_range(99, 0);
		if (pick >= occ_pct) return '0;
		pick = $urandom_range(9, 0);
		if (pick == 0) return 8'hFF;
		if (pick == 1) return 8'h01;
		return PIX_W'($urandom_range(255, 1));
	endfunction

	task automatic queue_pixels(input int unsigned n, input int unsigned occ_pct);
		int unsigned i;
		for (i = 0; i < n; i++) pixel_backlog.push_back(random_pixel(occ_pct));
		items_queued += n;
	endtask

	// after a shrinking register write, send what is left of the frame so
	// the next frame starts on row 0
	task automatic finish_frame(input int unsigned occ_pct);
		int unsigned w;
		int unsigned h;
		int unsigned r;
		int unsigned c;
		int unsigned remaining;
		w = eff_width();
		h = eff_height();
		r = (next_row > h - 1) ? h - 1 : next_row;
		c = (next_col > w - 1) ? w - 1 : next_col;
		remaining = (r == 0 && c == 0) ? 0 : (h - 1 - r) * w + (w - c);
		queue_pixels(remaining, occ_pct);
		drain();
	endtask

	// a value register setting, now and then pinned to an extreme
	function automatic int unsigned pick_value();
		int unsigned pick;
		pick = $urandom_range(5, 0);
		if (pick == 0) return 0;
		if (pick == 1) return 255;
		return $urandom_range(255, 0);
	endfunction

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		int unsigned i;
		int unsigned it;
		int unsigned w_raw;
		int unsigned h_raw;
		int unsigned w_eff;
		int unsigned h_eff;
		int unsigned occ;
		int unsigned k;
		bit          broken;

		for (i = 0; i < 3; i++) begin
			win[i][0] = '0;
			win[i][1] = '0;
			win[i][2] = '0;
		end
		next_row   = 0;
		next_col   = 0;
		width_reg  = WIDTH_RESET;
		height_reg = HEIGHT_RESET;
		sparse_val = SPARSE_RESET;
		dense_val  = DENSE_RESET;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// --- directed: every branch of the neighbor rule on a 5x4 frame
		write_reg(REG_WIDTH, 5);
		write_reg(REG_HEIGHT, 4);
		write_reg(REG_SPARSE, 8'h5A);
		write_reg(REG_DENSE, 8'hA5);
		for (i = 0; i < 20; i++) pixel_backlog.push_back(directed_px[i]);
		items_queued += 20;
		drain();

		// --- directed: clamped width/height, value extremes, ring count of four
		write_reg(REG_WIDTH, 0);
		write_reg(REG_HEIGHT, 2);
		write_reg(REG_SPARSE, 0);
		write_reg(REG_DENSE, 255);
		for (i = 20; i < DIRECTED_ITEMS; i++) pixel_backlog.push_back(directed_px[i]);
		items_queued += DIRECTED_ITEMS - 20;
		drain();

		// --- random frames, mostly small, a fifth of them cut short by a
		// shrinking register write that pushes the counters past the end
		it = 0;
		while (items_queued < DIRECTED_ITEMS + RANDOM_ITEMS) begin
			if (items_queued >= DIRECTED_ITEMS + RANDOM_ITEMS / 2) begin
				send_idle_pct = 45;
				recv_idle_pct = 9;
			end
			k = $urandom_range(19, 0);
			if (it == 0) w_raw = 8;
			else if (it == 1) w_raw = 6;
			else if (k == 0) w_raw = $urandom_range(2, 0);
			else if (k == 1) w_raw = $urandom_range(40, 20);
			else w_raw = $urandom_range(8, 3);
			k = $urandom_range(9, 0);
			if (it == 0) h_raw = 6;
			else if (it == 1) h_raw = 5;
			else if (k == 0) h_raw = $urandom_range(2, 0);
			else h_raw = $urandom_range(6, 3);
			write_reg(REG_WIDTH, w_raw);
			write_reg(REG_HEIGHT, h_raw);
			write_reg(REG_SPARSE, pick_value());
			write_reg(REG_DENSE, pick_value());
			w_eff = eff_width();
			h_eff = eff_height();
			occ = $urandom_range(95, 20);
			broken = (it == 1) || (it > 1 && $urandom_range(99, 0) < 20);
			if (it == 0) hold_armed = 1'b1;  // stall the receiver on a 48-pixel frame
			if (!broken) begin
				queue_pixels(w_eff * h_eff * ((it == 0) ? 1 : $urandom_range(2, 1)), occ);
				drain();
			end else begin
				// the first cut stops two pixels short so both counters overshoot
				k = (it == 1) ? w_eff * h_eff - 2 : $urandom_range(w_eff * h_eff - 1, 1);
				queue_pixels(k, occ);
				drain();
				write_reg(REG_WIDTH, (it == 1) ? 1 : $urandom_range(w_eff, 0));
				write_reg(REG_HEIGHT, (it == 1) ? 0 : $urandom_range(h_eff, 0));
				finish_frame(occ);
			end
			it++;
		end

		// --- register extremes with no idling: the tallest and the widest
		// frame are started, then cut short by a shrinking write
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_reg(REG_WIDTH, 3);
		write_reg(REG_HEIGHT, 12'hFFF);
		write_reg(REG_SPARSE, 255);
		write_reg(REG_DENSE, 0);
		queue_pixels(3 * 12, 60);
		drain();
		write_reg(REG_HEIGHT, 3);
		finish_frame(60);
		write_reg(REG_WIDTH, 12'hFFF);
		queue_pixels(40, 45);
		drain();
		write_reg(REG_WIDTH, 3);
		finish_frame(45);

		$display("Run covered %0d pixels in %0d random frames plus directed and extreme-register frames",
			pixels_accepted, it);
		$display("%0d tagged results checked, %0d field mismatches", results_checked, mismatches);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
